// ----- src/pbapt_pkg.sv -----
package pbapt_pkg;

    localparam int COORD_W      = 16;
    localparam int MAX_VERTICES = 256;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int MUL_W        = COORD_W + 1;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int SUM_W        = 48;
    localparam int AREA_W       = 47;
    localparam int COUNT_W      = 9;
    localparam int COUNT_MAX    = (1 << COUNT_W) - 1;
    localparam int VTX_W        = 2 * COORD_W;

    // input word layout
    localparam int IN_X_LSB     = 0;
    localparam int IN_Y_LSB     = COORD_W;
    localparam int IN_NEW_BIT   = 2 * COORD_W;
    localparam int IN_RAW_W     = 2 * COORD_W + 1;
    localparam int IN_DATA_W    = ((IN_RAW_W + 7) / 8) * 8;

    // output word layout
    localparam int OUT_INSIDE_BIT = 0;
    localparam int OUT_MIN_X_LSB  = 1;
    localparam int OUT_MIN_Y_LSB  = OUT_MIN_X_LSB + COORD_W;
    localparam int OUT_MAX_X_LSB  = OUT_MIN_Y_LSB + COORD_W;
    localparam int OUT_MAX_Y_LSB  = OUT_MAX_X_LSB + COORD_W;
    localparam int OUT_MID_X_LSB  = OUT_MAX_Y_LSB + COORD_W;
    localparam int OUT_MID_Y_LSB  = OUT_MID_X_LSB + COORD_W;
    localparam int OUT_AREA_LSB   = OUT_MID_Y_LSB + COORD_W;
    localparam int OUT_COUNT_LSB  = OUT_AREA_LSB + AREA_W;
    localparam int OUT_OVF_BIT    = OUT_COUNT_LSB + COUNT_W;
    localparam int OUT_RAW_W      = OUT_OVF_BIT + 1;
    localparam int OUT_DATA_W     = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_QUERY   = 1'b1;
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_QUERY   = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LD_STORE,
        S_LD_M1,
        S_LD_M2,
        S_LD_ACC,
        S_LD_TAIL,
        S_CL_M1,
        S_CL_M2,
        S_CL_SUB,
        S_CL_ABS,
        S_Q_START,
        S_Q_J,
        S_Q_EDGE,
        S_Q_M1,
        S_Q_M2,
        S_Q_CMP,
        S_EMIT
    } t_state;

    function automatic logic signed [MUL_W-1:0] sext_c(input logic signed [COORD_W-1:0] a);
        sext_c = {a[COORD_W-1], a};
    endfunction

    function automatic logic signed [MUL_W-1:0] sub_c(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b);
        sub_c = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    endfunction

endpackage

// ----- src/polygon_bounds_area_and_point_test_core.sv -----
// Vertex load: store, multiply-accumulate unless first vertex or full store; last closes the sum.
// Query on n >= 3 vertices in the box: multiply and compare per edge straddling the query row;
// a query rejected early skips them. A result word not yet taken stalls the input.
// Throughput: one word at a time, set by the single 17x17 multiplier and the store read port.
// Reset (synchronous, active low) clears count, bounds, area sum, drop flag and output valid;
// the vertex store is not cleared and entries at or above the count are never read.
module polygon_bounds_area_and_point_test_core import pbapt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // x, y, new_shape
    input  logic                  s_axis_tuser,  // func
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // inside_res, min_x, min_y, max_x, max_y,
                                                 // mid_x, mid_y, double_area, vertex_count,
                                                 // overflow
    output logic                  m_axis_tuser   // kind
);

    t_state r_state, n_state;

    // shape state
    logic        [CNT_W-1:0]   r_count;
    logic signed [COORD_W-1:0] r_min_x, r_min_y, r_max_x, r_max_y;
    logic signed [COORD_W-1:0] r_prev_x, r_prev_y;
    logic signed [SUM_W-1:0]   r_sum;
    logic                      r_drop;

    // working registers
    logic                      r_func, r_last;
    logic signed [COORD_W-1:0] r_x, r_y;
    logic signed [COORD_W-1:0] r_xi, r_yi, r_xj, r_yj;
    logic        [IDX_W-1:0]   r_idx;
    logic                      r_in;
    logic signed [SUM_W-1:0]   r_acc;
    logic signed [PROD_W-1:0]  r_prod, r_lhs;

    // vertex store
    logic [VTX_W-1:0] r_mem [MAX_VERTICES];
    logic [VTX_W-1:0] r_rd_data;
    logic             rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;

    logic signed [MUL_W-1:0] mul_a, mul_b;

    logic                      r_m_valid, r_m_user;
    logic [OUT_DATA_W-1:0]     r_m_data, res_data;
    logic                      m_load;

    logic                      accept, full, count_zero, last_edge, crossing, hit, outside;
    logic signed [COORD_W-1:0] rd_x, rd_y;
    logic signed [MUL_W-1:0]   d_edge, mid_sx, mid_sy, mid_ax, mid_ay;
    logic signed [SUM_W-1:0]   prod_ext;
    logic [AREA_W-1:0]         area;
    logic [COUNT_W-1:0]        cnt_out;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    assign full       = (r_count >= CNT_W'(MAX_VERTICES));
    assign count_zero = (r_count == '0);
    assign last_edge  = ({1'b0, r_idx} == r_count - CNT_W'(1));
    assign rd_x       = r_rd_data[COORD_W-1:0];
    assign rd_y       = r_rd_data[VTX_W-1:COORD_W];
    assign crossing   = (rd_y > r_y) != (r_yj > r_y);
    assign d_edge     = sub_c(r_yj, r_yi);
    assign hit        = (!d_edge[MUL_W-1] && d_edge != '0) ? (r_lhs < r_prod) : (r_lhs > r_prod);
    assign outside    = (r_x < r_min_x) || (r_x > r_max_x) || (r_y < r_min_y) || (r_y > r_max_y);
    assign prod_ext   = {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = r_count[IDX_W-1:0];
        mul_a   = '0;
        mul_b   = '0;
        m_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (s_axis_tuser == FUNC_QUERY) ? S_Q_START : S_LD_STORE;
                end
            end
            S_LD_STORE: begin
                if (!full) begin
                    wr_en   = 1'b1;
                    n_state = count_zero ? S_LD_TAIL : S_LD_M1;
                end else begin
                    n_state = S_LD_TAIL;
                end
            end
            S_LD_M1: begin
                mul_a   = sext_c(r_prev_x);
                mul_b   = sext_c(r_y);
                n_state = S_LD_M2;
            end
            S_LD_M2: begin
                mul_a   = sext_c(r_x);
                mul_b   = sext_c(r_prev_y);
                n_state = S_LD_ACC;
            end
            S_LD_ACC: n_state = S_LD_TAIL;
            S_LD_TAIL: begin
                if (r_last) begin
                    // fetch the first vertex for the closing edge
                    rd_en   = 1'b1;
                    n_state = S_CL_M1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CL_M1: begin
                mul_a   = sext_c(r_prev_x);
                mul_b   = sext_c(rd_y);
                n_state = S_CL_M2;
            end
            S_CL_M2: begin
                mul_a   = sext_c(rd_x);
                mul_b   = sext_c(r_prev_y);
                n_state = S_CL_SUB;
            end
            S_CL_SUB: n_state = S_CL_ABS;
            S_CL_ABS: n_state = S_EMIT;
            S_Q_START: begin
                if (r_count < CNT_W'(3) || outside) begin
                    n_state = S_EMIT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(r_count - CNT_W'(1));
                    n_state = S_Q_J;
                end
            end
            S_Q_J: begin
                rd_en   = 1'b1;
                n_state = S_Q_EDGE;
            end
            S_Q_EDGE: begin
                if (crossing) begin
                    n_state = S_Q_M1;
                end else if (last_edge) begin
                    n_state = S_EMIT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx + IDX_W'(1);
                end
            end
            S_Q_M1: begin
                mul_a   = sub_c(r_x, r_xi);
                mul_b   = sub_c(r_yj, r_yi);
                n_state = S_Q_M2;
            end
            S_Q_M2: begin
                mul_a   = sub_c(r_xj, r_xi);
                mul_b   = sub_c(r_y, r_yi);
                n_state = S_Q_CMP;
            end
            S_Q_CMP: begin
                if (last_edge) begin
                    n_state = S_EMIT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx + IDX_W'(1);
                    n_state = S_Q_EDGE;
                end
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!r_m_valid || m_axis_tready) begin
                    m_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= {r_y, r_x};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // shared multiplier
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_min_x  <= '0;
            r_min_y  <= '0;
            r_max_x  <= '0;
            r_max_y  <= '0;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_sum    <= '0;
            r_drop   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept && s_axis_tuser == FUNC_LOAD && s_axis_tdata[IN_NEW_BIT]) begin
                        r_count  <= '0;
                        r_min_x  <= '0;
                        r_min_y  <= '0;
                        r_max_x  <= '0;
                        r_max_y  <= '0;
                        r_prev_x <= '0;
                        r_prev_y <= '0;
                        r_sum    <= '0;
                        r_drop   <= 1'b0;
                    end
                end
                S_LD_STORE: begin
                    if (!full) begin
                        r_count <= r_count + CNT_W'(1);
                        if (count_zero) begin
                            r_min_x  <= r_x;
                            r_max_x  <= r_x;
                            r_min_y  <= r_y;
                            r_max_y  <= r_y;
                            r_prev_x <= r_x;
                            r_prev_y <= r_y;
                        end else begin
                            if (r_x < r_min_x) r_min_x <= r_x;
                            if (r_x > r_max_x) r_max_x <= r_x;
                            if (r_y < r_min_y) r_min_y <= r_y;
                            if (r_y > r_max_y) r_max_y <= r_y;
                        end
                    end else begin
                        r_drop <= 1'b1;
                    end
                end
                S_LD_M2: r_sum <= r_sum + prod_ext;
                S_LD_ACC: begin
                    r_sum    <= r_sum - prod_ext;
                    r_prev_x <= r_x;
                    r_prev_y <= r_y;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_func <= s_axis_tuser;
                    r_last <= s_axis_tlast;
                    r_x    <= s_axis_tdata[IN_X_LSB +: COORD_W];
                    r_y    <= s_axis_tdata[IN_Y_LSB +: COORD_W];
                end
            end
            S_CL_M2:  r_acc <= r_sum + prod_ext;
            S_CL_SUB: r_acc <= r_acc - prod_ext;
            S_CL_ABS: begin
                if (r_acc[SUM_W-1]) r_acc <= -r_acc;
            end
            S_Q_START: begin
                // a single vertex is hit only by an exact match
                r_in <= (r_count == CNT_W'(1)) && (r_x == r_min_x) && (r_y == r_min_y);
            end
            S_Q_J: begin
                r_xj  <= rd_x;
                r_yj  <= rd_y;
                r_idx <= '0;
            end
            S_Q_EDGE: begin
                if (crossing) begin
                    r_xi <= rd_x;
                    r_yi <= rd_y;
                end else begin
                    r_xj  <= rd_x;
                    r_yj  <= rd_y;
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            S_Q_M2: r_lhs <= r_prod;
            S_Q_CMP: begin
                r_in  <= r_in ^ hit;
                r_xj  <= r_xi;
                r_yj  <= r_yi;
                r_idx <= r_idx + IDX_W'(1);
            end
            default: ;
        endcase
    end

    // centre, rounded toward zero
    assign mid_sx  = sext_c(r_min_x) + sext_c(r_max_x);
    assign mid_sy  = sext_c(r_min_y) + sext_c(r_max_y);
    assign mid_ax  = mid_sx + MUL_W'(mid_sx[MUL_W-1]);
    assign mid_ay  = mid_sy + MUL_W'(mid_sy[MUL_W-1]);
    assign area    = (|r_acc[SUM_W-1:AREA_W]) ? '1 : r_acc[AREA_W-1:0];
    assign cnt_out = (r_count > CNT_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : COUNT_W'(r_count);

    always_comb begin
        res_data = '0;
        if (r_func == FUNC_QUERY) begin
            res_data[OUT_INSIDE_BIT] = r_in;
        end else begin
            res_data[OUT_MIN_X_LSB +: COORD_W] = r_min_x;
            res_data[OUT_MIN_Y_LSB +: COORD_W] = r_min_y;
            res_data[OUT_MAX_X_LSB +: COORD_W] = r_max_x;
            res_data[OUT_MAX_Y_LSB +: COORD_W] = r_max_y;
            res_data[OUT_MID_X_LSB +: COORD_W] = mid_ax[MUL_W-1:1];
            res_data[OUT_MID_Y_LSB +: COORD_W] = mid_ay[MUL_W-1:1];
            res_data[OUT_AREA_LSB +: AREA_W]   = area;
            res_data[OUT_COUNT_LSB +: COUNT_W] = cnt_out;
            res_data[OUT_OVF_BIT]              = r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (m_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_load) begin
            r_m_data <= res_data;
            r_m_user <= (r_func == FUNC_QUERY) ? KIND_QUERY : KIND_SUMMARY;
        end
    end

endmodule

// ----- src/pbapt_checker.sv -----
module pbapt_checker import pbapt_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic                  s_axis_tuser,
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // one word in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    // an answer carries only the inside bit
    a_query_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_QUERY |->
            m_axis_tdata[OUT_DATA_W-1:1] == '0)
        else $error("query answer has geometry bits set");

    // a summary has an ordered box and a count within capacity
    a_summary_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_SUMMARY |->
            !m_axis_tdata[OUT_INSIDE_BIT]
            && $signed(m_axis_tdata[OUT_MIN_X_LSB +: COORD_W])
               <= $signed(m_axis_tdata[OUT_MAX_X_LSB +: COORD_W])
            && $signed(m_axis_tdata[OUT_MIN_Y_LSB +: COORD_W])
               <= $signed(m_axis_tdata[OUT_MAX_Y_LSB +: COORD_W])
            && m_axis_tdata[OUT_COUNT_LSB +: COUNT_W] != '0
            && m_axis_tdata[OUT_COUNT_LSB +: COUNT_W] <= COUNT_W'(MAX_VERTICES))
        else $error("summary fields out of order");

endmodule

bind polygon_bounds_area_and_point_test_core pbapt_checker u_pbapt_checker (.*);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import pbapt_pkg::*;

    localparam int     CYCLE_LIMIT  = 4000000;
    localparam int     RANDOM_WORDS = 700;
    localparam int     LONG_HOLD    = 400;
    localparam int     SETTLE       = 40;
    localparam int     NPLAN        = 24;
    localparam int     C_MIN        = -(1 << (COORD_W - 1));
    localparam int     C_MAX        = (1 << (COORD_W - 1)) - 1;
    localparam longint AREA_SAT     = (longint'(1) << AREA_W) - 1;

    typedef struct packed {
        logic               func;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               new_shape;
        logic               last;
    } t_word;

    typedef struct packed {
        logic               kind;
        logic               hit;
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] max_y;
        logic [COORD_W-1:0] mid_x;
        logic [COORD_W-1:0] mid_y;
        logic [AREA_W-1:0]  area;
        logic [COUNT_W-1:0] vcount;
        logic               ovf;
    } t_answer;

    typedef struct packed {
        t_word   w;
        logic    known;
        t_answer ans;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // x, y, new_shape
    logic                  s_axis_tuser;   // func
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // inside_res, min_x, min_y, max_x, max_y,
                                           // mid_x, mid_y, double_area, vertex_count,
                                           // overflow
    logic                  m_axis_tuser;   // kind

    // shadow copy of the polygon held by the block
    longint  vtx_x [MAX_VERTICES];
    longint  vtx_y [MAX_VERTICES];
    int      held_cnt  = 0;
    longint  box_lo_x  = 0;
    longint  box_lo_y  = 0;
    longint  box_hi_x  = 0;
    longint  box_hi_y  = 0;
    longint  chain_sum = 0;
    longint  tail_x    = 0;
    longint  tail_y    = 0;
    logic    dropped   = 1'b0;

    t_answer answers_due [$];
    int      mismatches  = 0;
    int      cycles      = 0;
    int      words_sent  = 0;
    int      holds_asked = 0;
    logic    feed_burst  = 1'b0;

    polygon_bounds_area_and_point_test_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic t_word make_word(logic func, int x, int y, logic fresh, logic close);
        t_word w;
        w.func      = func;
        w.x         = x[COORD_W-1:0];
        w.y         = y[COORD_W-1:0];
        w.new_shape = fresh;
        w.last      = close;
        return w;
    endfunction

    function automatic t_row load_row(int x, int y, logic fresh, logic close);
        t_row r;
        r   = '0;
        r.w = make_word(FUNC_LOAD, x, y, fresh, close);
        return r;
    endfunction

    // junk sets the load-only flags, which a query must ignore
    function automatic t_row query_row(int x, int y, logic junk);
        t_row r;
        r   = '0;
        r.w = make_word(FUNC_QUERY, x, y, junk, junk);
        return r;
    endfunction

    function automatic t_row query_known(int x, int y, logic hit);
        t_row r;
        r           = query_row(x, y, 1'b0);
        r.known     = 1'b1;
        r.ans.kind  = KIND_QUERY;
        r.ans.hit   = hit;
        return r;
    endfunction

    function automatic t_row load_known(int x, int y, logic fresh, int lo_x, int lo_y,
                                        int hi_x, int hi_y, int mx, int my,
                                        longint area, int cnt);
        t_row r;
        r            = load_row(x, y, fresh, 1'b1);
        r.known      = 1'b1;
        r.ans.kind   = KIND_SUMMARY;
        r.ans.min_x  = lo_x[COORD_W-1:0];
        r.ans.min_y  = lo_y[COORD_W-1:0];
        r.ans.max_x  = hi_x[COORD_W-1:0];
        r.ans.max_y  = hi_y[COORD_W-1:0];
        r.ans.mid_x  = mx[COORD_W-1:0];
        r.ans.mid_y  = my[COORD_W-1:0];
        r.ans.area   = area[AREA_W-1:0];
        r.ans.vcount = cnt[COUNT_W-1:0];
        return r;
    endfunction

    t_row plan [NPLAN] = '{
        query_known(0, 0, 1'b0),
        load_known(C_MIN, C_MAX, 1'b1, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 0, 1),
        query_known(C_MIN, C_MAX, 1'b1),
        query_known(C_MIN, C_MAX - 1, 1'b0),
        load_known(C_MAX, C_MIN, 1'b0, C_MIN, C_MIN, C_MAX, C_MAX, 0, 0, 0, 2),
        query_known(0, 0, 1'b0),
        load_row(-100, -100, 1'b1, 1'b0),
        load_row(100, -100, 1'b0, 1'b0),
        load_row(100, 100, 1'b0, 1'b0),
        load_row(-100, 100, 1'b0, 1'b1),
        query_row(0, 0, 1'b0),
        query_row(100, 0, 1'b0),
        query_row(-100, 0, 1'b0),
        query_row(0, -100, 1'b0),
        query_known(200, 0, 1'b0),
        load_row(0, 50, 1'b0, 1'b1),
        query_row(0, 75, 1'b1),
        load_row(C_MIN, C_MIN, 1'b1, 1'b0),
        load_row(C_MAX, C_MIN, 1'b0, 1'b0),
        load_row(C_MAX, C_MAX, 1'b0, 1'b1),
        query_row(C_MAX, C_MAX, 1'b0),
        query_row(C_MIN, C_MAX, 1'b0),
        query_row(0, -1, 1'b1),
        query_row(100, -200, 1'b0)
    };

    // crossing-number rule with exact cross-multiplication
    function automatic logic point_inside(longint px, longint py);
        logic   odd;
        int     j;
        longint d, lhs, rhs;
        odd = 1'b0;
        if (held_cnt == 1)
            return (px == vtx_x[0]) && (py == vtx_y[0]);
        if (held_cnt < 3)
            return 1'b0;
        if (px < box_lo_x || px > box_hi_x || py < box_lo_y || py > box_hi_y)
            return 1'b0;
        j = held_cnt - 1;
        for (int i = 0; i < held_cnt; i++) begin
            if ((vtx_y[i] > py) != (vtx_y[j] > py)) begin
                d   = vtx_y[j] - vtx_y[i];
                lhs = (px - vtx_x[i]) * d;
                rhs = (vtx_x[j] - vtx_x[i]) * (py - vtx_y[i]);
                if ((d > 0) ? (lhs < rhs) : (lhs > rhs))
                    odd = !odd;
            end
            j = i;
        end
        return odd;
    endfunction

    // advance the shadow polygon by one word; return 1 when a result is due
    function automatic logic polygon_step(input t_word w, output t_answer a);
        longint px, py, total, mag, mx, my;
        int     shown;
        px = longint'($signed(w.x));
        py = longint'($signed(w.y));
        a  = '0;
        if (w.func == FUNC_QUERY) begin
            a.kind = KIND_QUERY;
            a.hit  = point_inside(px, py);
            return 1'b1;
        end
        if (w.new_shape) begin
            held_cnt  = 0;
            box_lo_x  = 0;
            box_lo_y  = 0;
            box_hi_x  = 0;
            box_hi_y  = 0;
            chain_sum = 0;
            tail_x    = 0;
            tail_y    = 0;
            dropped   = 1'b0;
        end
        if (held_cnt < MAX_VERTICES) begin
            if (held_cnt == 0) begin
                box_lo_x = px;
                box_hi_x = px;
                box_lo_y = py;
                box_hi_y = py;
            end else begin
                if (px < box_lo_x) box_lo_x = px;
                if (px > box_hi_x) box_hi_x = px;
                if (py < box_lo_y) box_lo_y = py;
                if (py > box_hi_y) box_hi_y = py;
                chain_sum += tail_x * py - px * tail_y;
            end
            vtx_x[held_cnt] = px;
            vtx_y[held_cnt] = py;
            tail_x = px;
            tail_y = py;
            held_cnt++;
        end else begin
            dropped = 1'b1;
        end
        if (!w.last)
            return 1'b0;
        a.kind = KIND_SUMMARY;
        if (held_cnt > 0) begin
            // fold in the closing edge without keeping it in the running sum
            total = chain_sum + tail_x * vtx_y[0] - vtx_x[0] * tail_y;
            mag   = (total < 0) ? -total : total;
            if (mag > AREA_SAT)
                mag = AREA_SAT;
            mx    = (box_lo_x + box_hi_x) / 2;
            my    = (box_lo_y + box_hi_y) / 2;
            shown = (held_cnt > COUNT_MAX) ? COUNT_MAX : held_cnt;
            a.min_x  = box_lo_x[COORD_W-1:0];
            a.min_y  = box_lo_y[COORD_W-1:0];
            a.max_x  = box_hi_x[COORD_W-1:0];
            a.max_y  = box_hi_y[COORD_W-1:0];
            a.mid_x  = mx[COORD_W-1:0];
            a.mid_y  = my[COORD_W-1:0];
            a.area   = mag[AREA_W-1:0];
            a.vcount = shown[COUNT_W-1:0];
        end
        a.ovf = dropped;
        return 1'b1;
    endfunction

    function automatic string show(t_answer a);
        return $sformatf("kind=%0d in=%0d box=(%0d,%0d)-(%0d,%0d) mid=(%0d,%0d) area=%0d n=%0d ovf=%0d",
                         a.kind, a.hit, $signed(a.min_x), $signed(a.min_y), $signed(a.max_x),
                         $signed(a.max_y), $signed(a.mid_x), $signed(a.mid_y), a.area,
                         a.vcount, a.ovf);
    endfunction

    task automatic note_mismatch(string what, t_answer want, t_answer got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s) at cycle %0d\n  expected %s\n  actual   %s",
                     what, cycles, show(want), show(got));
    endtask

    task automatic send_word(input t_word w, input logic known, input t_answer typed);
        logic [IN_DATA_W-1:0] bits;
        t_answer              want;
        t_answer              due;
        int                   gap;
        if ($urandom_range(0, 39) == 0)
            feed_burst = !feed_burst;
        gap = feed_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        bits = '0;
        bits[IN_X_LSB +: COORD_W] = w.x;
        bits[IN_Y_LSB +: COORD_W] = w.y;
        bits[IN_NEW_BIT]          = w.new_shape;
        s_axis_tdata  <= bits;
        s_axis_tuser  <= w.func;
        s_axis_tlast  <= w.last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
        if (polygon_step(w, want)) begin
            due         = known ? typed : want;
            answers_due = {answers_due, due};
        end
    endtask

    function automatic int clamp_coord(int v);
        if (v < C_MIN) return C_MIN;
        if (v > C_MAX) return C_MAX;
        return v;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, (1 << COORD_W) - 1)) + C_MIN;
    endfunction

    function automatic int near(int centre, int span);
        return clamp_coord(centre + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // tiny spans give repeated rows and collinear edges
    function automatic int pick_span();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 4;
        if (r < 7) return 60;
        if (r < 9) return 3000;
        return C_MAX;
    endfunction

    task automatic send_shape(int n, logic fresh, logic close, int span);
        int cx, cy;
        cx = (span >= C_MAX) ? 0 : any_coord();
        cy = (span >= C_MAX) ? 0 : any_coord();
        for (int k = 0; k < n; k++)
            send_word(make_word(FUNC_LOAD, near(cx, span), near(cy, span),
                                fresh && k == 0, close && k == n - 1), 1'b0, '0);
    endtask

    task automatic send_queries(int q, logic wild);
        int px, py, r, pick;
        for (int k = 0; k < q; k++) begin
            r  = wild ? 99 : $urandom_range(0, 99);
            px = any_coord();
            py = any_coord();
            if (r < 40 && held_cnt > 0) begin
                px = clamp_coord(int'(box_lo_x) - 2 +
                                 int'($urandom_range(0, int'(box_hi_x - box_lo_x) + 4)));
                py = clamp_coord(int'(box_lo_y) - 2 +
                                 int'($urandom_range(0, int'(box_hi_y - box_lo_y) + 4)));
            end else if (r < 80 && held_cnt > 0) begin
                // land on a vertex, or on its row
                pick = $urandom_range(0, held_cnt - 1);
                py   = int'(vtx_y[pick]);
                px   = (r < 60) ? int'(vtx_x[pick]) : clamp_coord(int'(box_lo_x) +
                       int'($urandom_range(0, int'(box_hi_x - box_lo_x))));
            end
            send_word(make_word(FUNC_QUERY, px, py, wild && $urandom_range(0, 1),
                                wild && $urandom_range(0, 1)), 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        int   start, done, r;
        logic big_done;
        big_done = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k])
            send_word(plan[k].w, plan[k].known, plan[k].ans);

        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            done = words_sent - start;
            if ((holds_asked == 0 && done >= 100) || (holds_asked == 1 && done >= 500))
                holds_asked++;
            if (!big_done && done >= 300) begin
                // fill the store, then push past it
                big_done = 1'b1;
                send_shape(MAX_VERTICES, 1'b1, 1'b1, 400);
                send_queries(3, 1'b0);
                send_shape(3, 1'b0, 1'b1, 400);
                send_queries(2, 1'b0);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    send_shape(($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                                           : $urandom_range(3, 10),
                               1'b1, 1'b1, pick_span());
                    send_queries($urandom_range(1, 6), 1'b0);
                end else if (r < 75) begin
                    send_shape($urandom_range(1, 3), 1'b0, 1'($urandom_range(0, 1)),
                               pick_span());
                    send_queries($urandom_range(1, 3), 1'b0);
                end else if (r < 85) begin
                    send_queries($urandom_range(1, 4), 1'b1);
                end else begin
                    repeat ($urandom_range(1, 5))
                        send_word(make_word(FUNC_LOAD, any_coord(), any_coord(),
                                            $urandom_range(0, 7) == 0,
                                            1'($urandom_range(0, 1))),
                                  1'b0, '0);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0)
            $display("** polygon_bounds_area_and_point_test_core: PASSED **");
        else
            $display("** polygon_bounds_area_and_point_test_core: FAILED **");
        $finish;
    end

    initial begin : drain
        int   pause, holds_done;
        logic drain_burst;
        holds_done  = 0;
        drain_burst = 1'b0;
        m_axis_tready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (holds_done < holds_asked) begin
                // hold off long enough for the block to back up into its input
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if ($urandom_range(0, 39) == 0)
                drain_burst = !drain_burst;
            pause = drain_burst ? 0 : $urandom_range(0, 3);
            if (pause > 0) begin
                m_axis_tready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin : check_words
        t_answer got, want;
        if (i_rst_n === 1'b1 && m_axis_tvalid && m_axis_tready) begin
            got.kind   = m_axis_tuser;
            got.hit    = m_axis_tdata[OUT_INSIDE_BIT];
            got.min_x  = m_axis_tdata[OUT_MIN_X_LSB +: COORD_W];
            got.min_y  = m_axis_tdata[OUT_MIN_Y_LSB +: COORD_W];
            got.max_x  = m_axis_tdata[OUT_MAX_X_LSB +: COORD_W];
            got.max_y  = m_axis_tdata[OUT_MAX_Y_LSB +: COORD_W];
            got.mid_x  = m_axis_tdata[OUT_MID_X_LSB +: COORD_W];
            got.mid_y  = m_axis_tdata[OUT_MID_Y_LSB +: COORD_W];
            got.area   = m_axis_tdata[OUT_AREA_LSB +: AREA_W];
            got.vcount = m_axis_tdata[OUT_COUNT_LSB +: COUNT_W];
            got.ovf    = m_axis_tdata[OUT_OVF_BIT];
            if (answers_due.size() == 0) begin
                note_mismatch("no word pending", '0, got);
            end else begin
                want = answers_due.pop_front();
                if (got !== want)
                    note_mismatch("field differs", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** polygon_bounds_area_and_point_test_core: FAILED **");
            $finish;
        end
    end

endmodule
